[design/lfca_pkg.sv]
// ----------------------------------------------------------------------------
// lfca_pkg
// Shared constants, types and helpers for the largest-free-chunk allocator.
// ----------------------------------------------------------------------------
package lfca_pkg;

    localparam int NUM_CHUNKS = 16;
    localparam int BYTE_WIDTH = 32;
    localparam int CHUNK_IW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    typedef logic [BYTE_WIDTH-1:0] t_bytes;
    typedef logic [CHUNK_IW-1:0]   t_chunk;

    // opcodes
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_GRANT   = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_RELEASE = 3'd2;
    localparam logic [2:0] ST_NOSPACE = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam t_bytes BYTE_MAX = '1;
    localparam t_chunk LAST_CHUNK = CHUNK_IW'(NUM_CHUNKS - 1);

    // tag riding along with a scan read
    typedef struct packed {
        logic   vld;
        t_chunk idx;
    } t_rd_tag;

    // running best candidate of a scan
    typedef struct packed {
        logic   vld;
        t_chunk idx;
        t_bytes val;
    } t_best;

    // low 32 bits of a byte value, zero-extended when narrower
    function automatic logic [31:0] to_out(input t_bytes v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

endpackage

[design/largest_free_chunk_allocator_top.sv]
// ----------------------------------------------------------------------------
// largest_free_chunk_allocator_top
// Worst-fit allocator over NUM_CHUNKS chunks with a sequencer around one
// compare unit and a count memory with one write port and one read port.
// ----------------------------------------------------------------------------
// Update and empty requests give a result without leaving idle; a release
// reads the count while idle and writes the saturated sum in S_REL. Each
// allocate result takes a scan (a count read per chunk through the shared
// max compare, one drain, one grant), up to 17 results; busy falls as the
// last result is strobed; results are never stalled.
// Reset (sync, active low) clears present marks; absent chunks read as zero.
// ----------------------------------------------------------------------------
module largest_free_chunk_allocator_top import lfca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_chunk_index,
    input  logic [31:0] i_byte_count,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [3:0]  o_granted_chunk,
    output logic [31:0] o_granted_bytes,
    output logic        o_last
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REL      = 3'd1;  // read-modify-write of a release
    localparam logic [2:0] S_SCAN     = 3'd2;  // issue one chunk read per cycle
    localparam logic [2:0] S_SCAN_END = 3'd3;  // last compare drains
    localparam logic [2:0] S_GRANT    = 3'd4;  // grant from best candidate

    logic [2:0]            r_state, n_state;
    t_bytes                r_bytes, n_bytes;     // remaining / operand bytes
    t_chunk                r_idx, n_idx;         // release target
    t_chunk                r_scan_idx, n_scan_idx;
    t_rd_tag               r_rd, n_rd;
    logic [NUM_CHUNKS-1:0] r_present, n_present;

    logic                  r_strobe, n_strobe;
    logic [2:0]            r_status, n_status;
    logic [3:0]            r_chunk, n_chunk;
    logic [31:0]           r_gbytes, n_gbytes;
    logic                  r_last, n_last;

    // memory and compare unit hookup
    logic   mem_we;
    t_chunk mem_waddr;
    t_bytes mem_wdata;
    t_chunk mem_raddr;
    t_bytes mem_rdata;
    logic   scan_clear;
    t_best  best;

    // datapath helpers
    t_bytes                in_bytes;
    t_chunk                in_idx;
    logic                  in_idx_ok;
    t_bytes                rel_cur;
    logic [BYTE_WIDTH:0]   rel_sum;
    logic [BYTE_WIDTH:0]   grant_diff;
    logic                  grant_whole;

    assign in_bytes  = BYTE_WIDTH'(64'(i_byte_count));
    assign in_idx    = CHUNK_IW'(i_chunk_index);
    assign in_idx_ok = (32'(i_chunk_index) < NUM_CHUNKS);

    // a chunk that is not present is treated as holding zero free bytes
    assign rel_cur    = r_present[r_idx] ? mem_rdata : '0;
    assign rel_sum    = {1'b0, rel_cur} + {1'b0, r_bytes};
    assign grant_diff = {1'b0, r_bytes} - {1'b0, best.val};
    assign grant_whole = !grant_diff[BYTE_WIDTH];  // remaining >= chunk count

    lfca_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lfca_maxscan u_maxscan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (scan_clear),
        .i_rd      (r_rd),
        .i_rdata   (mem_rdata),
        .i_present (r_present[r_rd.idx]),
        .o_best    (best)
    );

    always_comb begin
        n_state    = r_state;
        n_bytes    = r_bytes;
        n_idx      = r_idx;
        n_scan_idx = r_scan_idx;
        n_rd       = '0;
        n_present  = r_present;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_chunk    = r_chunk;
        n_gbytes   = r_gbytes;
        n_last     = r_last;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_bytes;
        mem_raddr  = r_scan_idx;
        scan_clear = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = in_idx;  // release reads the current count
                if (start) begin
                    n_bytes = in_bytes;
                    n_idx   = in_idx;
                    priority if (i_opcode == OP_UPDATE && in_idx_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = in_idx;
                        mem_wdata = in_bytes;
                        n_present[in_idx] = 1'b1;
                        n_strobe  = 1'b1;
                        n_status  = ST_UPDATED;
                        n_chunk   = i_chunk_index;
                        n_gbytes  = to_out(in_bytes);
                        n_last    = 1'b1;
                    end else if (i_opcode == OP_RELEASE && in_idx_ok) begin
                        n_state = S_REL;
                    end else if (i_opcode == OP_ALLOC) begin
                        if (in_bytes == '0) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                            n_chunk  = '0;
                            n_gbytes = '0;
                            n_last   = 1'b1;
                        end else begin
                            scan_clear = 1'b1;
                            n_scan_idx = '0;
                            n_state    = S_SCAN;
                        end
                    end else begin
                        // unused opcode or chunk out of range: no result
                        n_state = S_IDLE;
                    end
                end
            end

            S_REL: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = rel_sum[BYTE_WIDTH] ? BYTE_MAX : rel_sum[BYTE_WIDTH-1:0];
                n_present[r_idx] = 1'b1;
                n_strobe  = 1'b1;
                n_status  = ST_RELEASE;
                n_chunk   = 4'(r_idx);
                n_gbytes  = to_out(mem_wdata);
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end

            S_SCAN: begin
                mem_raddr  = r_scan_idx;
                n_rd.vld   = 1'b1;
                n_rd.idx   = r_scan_idx;
                if (r_scan_idx == LAST_CHUNK) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_scan_idx = r_scan_idx + t_chunk'(1);
                end
            end

            S_SCAN_END: begin
                n_state = S_GRANT;
            end

            S_GRANT: begin
                n_strobe = 1'b1;
                if (!best.vld) begin
                    n_status = ST_NOSPACE;
                    n_chunk  = '0;
                    n_gbytes = to_out(r_bytes);
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else if (grant_whole) begin
                    // whole chunk goes; unmarking leaves it reading as zero
                    n_present[best.idx] = 1'b0;
                    n_bytes  = grant_diff[BYTE_WIDTH-1:0];
                    n_status = ST_GRANT;
                    n_chunk  = 4'(best.idx);
                    n_gbytes = to_out(best.val);
                    n_last   = (grant_diff[BYTE_WIDTH-1:0] == '0);
                    if (grant_diff[BYTE_WIDTH-1:0] == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        scan_clear = 1'b1;
                        n_scan_idx = '0;
                        n_state    = S_SCAN;
                    end
                end else begin
                    // partial grant: chunk keeps the rest
                    mem_we    = 1'b1;
                    mem_waddr = best.idx;
                    mem_wdata = best.val - r_bytes;
                    n_status  = ST_GRANT;
                    n_chunk   = 4'(best.idx);
                    n_gbytes  = to_out(r_bytes);
                    n_last    = 1'b1;
                    n_bytes   = '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd      <= '0;
            r_present <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd      <= n_rd;
            r_present <= n_present;
            r_strobe  <= n_strobe;
        end
        r_bytes    <= n_bytes;
        r_idx      <= n_idx;
        r_scan_idx <= n_scan_idx;
        r_status   <= n_status;
        r_chunk    <= n_chunk;
        r_gbytes   <= n_gbytes;
        r_last     <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_granted_chunk = r_chunk;
    assign o_granted_bytes = r_gbytes;
    assign o_last          = r_last;

endmodule

[design/lfca_store.sv]
// ----------------------------------------------------------------------------
// lfca_store
// Free-byte count memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfca_store import lfca_pkg::*; (
    input  logic   i_clk,
    input  logic   i_we,
    input  t_chunk i_waddr,
    input  t_bytes i_wdata,
    input  t_chunk i_raddr,
    output t_bytes o_rdata
);

    t_bytes r_mem [NUM_CHUNKS];
    t_bytes r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/lfca_maxscan.sv]
// ----------------------------------------------------------------------------
// lfca_maxscan
// Shared compare unit: tracks the present chunk with the most free bytes,
// one chunk per cycle; later (higher) index wins on a tie.
// ----------------------------------------------------------------------------
module lfca_maxscan import lfca_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_clear,
    input  t_rd_tag i_rd,
    input  t_bytes  i_rdata,
    input  logic    i_present,
    output t_best   o_best
);

    t_best r_best;
    t_best n_best;

    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best.vld = 1'b0;
        end else if (i_rd.vld && i_present && (!r_best.vld || i_rdata >= r_best.val)) begin
            n_best.vld = 1'b1;
            n_best.idx = i_rd.idx;
            n_best.val = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.vld <= 1'b0;
        end else begin
            r_best.vld <= n_best.vld;
        end
        r_best.idx <= n_best.idx;
        r_best.val <= n_best.val;
    end

    assign o_best = r_best;

endmodule
